// ----- rtl/open_address_hash_insert_macros.svh -----
// assertion macros used by the checker
`ifndef OPEN_ADDRESS_HASH_INSERT_MACROS_SVH
`define OPEN_ADDRESS_HASH_INSERT_MACROS_SVH

// same-cycle implication
`define OAHI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OAHI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/oahi_pkg.sv -----
`timescale 1ns / 1ps
package oahi_pkg;

   localparam int KEY_W   = 16;
   localparam int DIGIT_W = 4;
   localparam int NDIG    = KEY_W / DIGIT_W;
   localparam int CNT_W   = $clog2(NDIG);
   localparam int SLOT_W  = 4;
   localparam int PROBE_W = 4;
   localparam int TOTAL_W = 16;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_PRESENT  = 2'd1,
      ST_FULL     = 2'd2,
      ST_HALTED   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_MOD,
      SQ_PROBE,
      SQ_EMIT
   } state_type;

endpackage

// ----- rtl/oahi_ram.sv -----
`timescale 1ns / 1ps
module oahi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/open_address_hash_insert.sv -----
// a halted block or a zero key goes straight from accept to the result,
// otherwise the key is reduced modulo the table size (four key bits per cycle), then probed; a
// full linear sweep reports full on its last probe
// a new item is taken only when idle; a stalled result holds off the next item
// each probe reads the table ram at the next slot while the current one is compared
// reset (synchronous, active high): empty table, zero total, halt clear, quadratic probing
`timescale 1ns / 1ps
module open_address_hash_insert #(
   parameter int TABLE_SIZE = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [oahi_pkg::KEY_W-1:0]      req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [oahi_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [1:0]                      rsp_status,
   output logic [oahi_pkg::PROBE_W-1:0]    rsp_probes,
   output logic [oahi_pkg::TOTAL_W-1:0]    rsp_collision_total,
   input  logic                            csr_wen,
   input  logic                            csr_wdata
);
   import oahi_pkg::*;

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int SW = $clog2(TABLE_SIZE + 1);

   function automatic logic [IW-1:0] mod_digit(input logic [IW-1:0] r,
                                                input logic [DIGIT_W-1:0] d);
      logic [IW:0]   t;
      logic [IW-1:0] acc;
      acc = r;
      for (int k = DIGIT_W - 1; k >= 0; k--) begin
         t = {acc, d[k]};
         if (t >= (IW+1)'(TABLE_SIZE)) begin
            t = t - (IW+1)'(TABLE_SIZE);
         end
         acc = t[IW-1:0];
      end
      return acc;
   endfunction

   state_type            state_ff, state_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [KEY_W-1:0]     dig_ff, dig_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IW-1:0]        j_ff, j_in;
   logic [IW:0]          inc_ff, inc_in;
   logic [SW-1:0]        steps_ff, steps_in;
   logic [TABLE_SIZE-1:0] valid_ff, valid_in;
   logic                 mode_ff, mode_in;
   logic                 halted_ff, halted_in;
   logic [TOTAL_W-1:0]   sum_ff, sum_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [PROBE_W-1:0]   rsp_probes_ff, rsp_probes_in;

   logic                 accept;
   logic                 ram_wr_en;
   logic [KEY_W-1:0]     ram_rd_data;
   logic [IW:0]          jsum;
   logic [TOTAL_W:0]     sum_wide;
   logic                 hit;
   logic                 empty;

   oahi_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (j_ff),
      .wr_data (key_ff),
      .rd_addr (j_in),
      .rd_data (ram_rd_data)
   );

   assign req_stall           = (state_ff != SQ_IDLE);
   assign accept              = req_valid && !req_stall;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_probes          = rsp_probes_ff;
   assign rsp_collision_total = sum_ff;

   assign empty = !valid_ff[j_ff];
   assign hit   = valid_ff[j_ff] && (ram_rd_data == key_ff);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      dig_in        = dig_ff;
      cnt_in        = cnt_ff;
      j_in          = j_ff;
      inc_in        = inc_ff;
      steps_in      = steps_ff;
      valid_in      = valid_ff;
      mode_in       = csr_wen ? csr_wdata : mode_ff;
      halted_in     = halted_ff;
      sum_in        = sum_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_probes_in = rsp_probes_ff;
      ram_wr_en     = 1'b0;
      jsum          = '0;
      sum_wide      = {1'b0, sum_ff} + (TOTAL_W+1)'(steps_ff);

      case (state_ff)
         SQ_IDLE: begin
            if (accept) begin
               key_in      = req_key;
               dig_in      = req_key;
               cnt_in      = '0;
               j_in        = '0;
               inc_in      = (IW+1)'(1);
               steps_in    = '0;
               res_slot_in = '0;
               if (halted_ff) begin
                  res_status_in = ST_HALTED;
                  state_in      = SQ_EMIT;
               end else if (req_key == '0) begin
                  res_status_in = ST_PRESENT;
                  state_in      = SQ_EMIT;
               end else begin
                  state_in = SQ_MOD;
               end
            end
         end
         SQ_MOD: begin
            j_in   = mod_digit(j_ff, dig_ff[KEY_W-1 -: DIGIT_W]);
            dig_in = dig_ff << DIGIT_W;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NDIG - 1)) begin
               state_in = SQ_PROBE;
            end
         end
         SQ_PROBE: begin
            if (hit) begin
               res_slot_in   = SLOT_W'(j_ff);
               res_status_in = ST_PRESENT;
               state_in      = SQ_EMIT;
            end else if (empty) begin
               ram_wr_en       = 1'b1;
               valid_in[j_ff]  = 1'b1;
               res_slot_in     = SLOT_W'(j_ff);
               res_status_in   = ST_INSERTED;
               state_in        = SQ_EMIT;
            end else if (mode_ff) begin
               if (inc_ff >= (IW+1)'(TABLE_SIZE)) begin
                  halted_in     = 1'b1;
                  res_slot_in   = '0;
                  res_status_in = ST_FULL;
                  state_in      = SQ_EMIT;
               end else begin
                  jsum = (IW+1)'(j_ff) + inc_ff;
                  if (jsum >= (IW+1)'(TABLE_SIZE)) begin
                     jsum = jsum - (IW+1)'(TABLE_SIZE);
                  end
                  j_in     = jsum[IW-1:0];
                  inc_in   = inc_ff + (IW+1)'(2);
                  steps_in = steps_ff + SW'(1);
               end
            end else begin
               jsum = (IW+1)'(j_ff) + (IW+1)'(1);
               if (jsum >= (IW+1)'(TABLE_SIZE)) begin
                  jsum = jsum - (IW+1)'(TABLE_SIZE);
               end
               j_in     = jsum[IW-1:0];
               steps_in = steps_ff + SW'(1);
               if (steps_in >= SW'(TABLE_SIZE)) begin
                  res_slot_in   = '0;
                  res_status_in = ST_FULL;
                  state_in      = SQ_EMIT;
               end
            end
         end
         SQ_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               rsp_probes_in = (32'(steps_ff) > 32'd15) ? '1 : PROBE_W'(steps_ff);
               sum_in        = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
               state_in      = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         valid_ff     <= '0;
         mode_ff      <= 1'b1;
         halted_ff    <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         mode_ff      <= mode_in;
         halted_ff    <= halted_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      dig_ff        <= dig_in;
      cnt_ff        <= cnt_in;
      j_ff          <= j_in;
      inc_ff        <= inc_in;
      steps_ff      <= steps_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_probes_ff <= rsp_probes_in;
   end

endmodule

// ----- rtl/oahi_check.sv -----
`timescale 1ns / 1ps
`include "open_address_hash_insert_macros.svh"
module oahi_check #(
   parameter int TABLE_SIZE = 11
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [oahi_pkg::SLOT_W-1:0]  rsp_slot,
   input logic [1:0]                   rsp_status,
   input logic [oahi_pkg::PROBE_W-1:0] rsp_probes,
   input logic [oahi_pkg::TOTAL_W-1:0] rsp_collision_total
);
   import oahi_pkg::*;

   // refused items carry no slot and no probes
   `OAHI_ASSERT_NOW(a_halt_empty, clock, reset, rsp_valid && (rsp_status == ST_HALTED), (rsp_slot == '0) && (rsp_probes == '0), "halted item with slot or probes")
   // a full table reports no slot
   `OAHI_ASSERT_NOW(a_full_slot, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_slot == '0, "full item with nonzero slot")
   // the running total never goes down
   `OAHI_ASSERT_NEXT(a_total_mono, clock, reset, !reset, rsp_collision_total >= $past(rsp_collision_total), "collision total decreased")
   // one item at a time
   `OAHI_ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall, "item taken while busy")

endmodule

bind open_address_hash_insert oahi_check #(
   .TABLE_SIZE (TABLE_SIZE)
) u_oahi_check (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_slot            (rsp_slot),
   .rsp_status          (rsp_status),
   .rsp_probes          (rsp_probes),
   .rsp_collision_total (rsp_collision_total)
);
